// ===== rtl/core/lru_page_replacement_assert.svh =====
// Assertion macros used by the checker file of the page replacement block.
// Each macro expects signals named clock and reset in the scope of use.
`ifndef LRU_PAGE_REPLACEMENT_ASSERT_SVH
`define LRU_PAGE_REPLACEMENT_ASSERT_SVH

// Same-cycle implication, switched off while reset is high.
`define LRUPR_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lrupr check failed");

// Next-cycle implication, switched off while reset is high.
`define LRUPR_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lrupr check failed");

// Next-cycle implication that also holds across reset.
`define LRUPR_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("lrupr check failed");

`endif

// ===== rtl/core/lrupr_pkg.sv =====
package lrupr_pkg;

   // Built number of page cells in the chain.
   localparam int MAX_SLOTS = 16;

   // Field widths.
   localparam int PAGE_W  = 32;
   localparam int COUNT_W = 32;
   localparam int CAP_W   = 5;

   // Occupancy must hold MAX_SLOTS itself; comparisons use the wider of the two.
   localparam int OCC_W = $clog2(MAX_SLOTS + 1);
   localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(4);

   // Per-cell control, decoded once in the top level for every cell.
   typedef struct packed {
      logic load;        // a transaction is accepted this cycle
      logic valid;       // the cell holds a resident page
      logic below_top;   // the cell is below the most recent resident page
      logic write_here;  // the referenced page lands in this cell
      logic full_miss;   // miss with the cache full: every cell below the top shifts down
   } lrupr_ctrl_type;

endpackage

// ===== rtl/core/lrupr_if.sv =====
// Reference channel.
interface lrupr_req_if;
   logic                          valid;
   logic                          ready;
   logic [lrupr_pkg::PAGE_W-1:0]  page_number;
   logic                          last_ref;

   modport source (output valid, output page_number, output last_ref, input ready);
   modport sink   (input valid, input page_number, input last_ref, output ready);
endinterface

// Result channel.
interface lrupr_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          hit;
   logic                          evicted_valid;
   logic [lrupr_pkg::PAGE_W-1:0]  evicted_page;
   logic [lrupr_pkg::COUNT_W-1:0] fault_total;
   logic [lrupr_pkg::COUNT_W-1:0] hit_total;
   logic                          is_last;

   modport source (output valid, output hit, output evicted_valid, output evicted_page,
                   output fault_total, output hit_total, output is_last, input ready);
   modport sink   (input valid, input hit, input evicted_valid, input evicted_page,
                   input fault_total, input hit_total, input is_last, output ready);
endinterface

// Configuration write channel for the cache size register.
interface lrupr_csr_if;
   logic                          valid;
   logic                          ready;
   logic [lrupr_pkg::CAP_W-1:0]   cache_size;

   modport source (output valid, output cache_size, input ready);
   modport sink   (input valid, input cache_size, output ready);
endinterface

// ===== rtl/core/lrupr_cell.sv =====
// One slot of the recency stack. Lower cells hold less recent pages. The cell
// compares its page with the reference, passes the "match seen" flag upwards
// and, when told to shift, takes the page of its upper neighbour.
module lrupr_cell (
   input  logic                          clock,
   input  lrupr_pkg::lrupr_ctrl_type     ctrl,
   input  logic [lrupr_pkg::PAGE_W-1:0]  req_page,
   input  logic [lrupr_pkg::PAGE_W-1:0]  upper_page,
   input  logic                          seen_in,
   output logic                          seen_out,
   output logic [lrupr_pkg::PAGE_W-1:0]  page_out
);

   logic [lrupr_pkg::PAGE_W-1:0] page_ff;
   logic [lrupr_pkg::PAGE_W-1:0] page_in;
   logic                         match;
   logic                         shift;

   // A hit here, or in any cell below, means this cell lies at or above the hit.
   assign match    = ctrl.valid && (page_ff == req_page);
   assign seen_out = seen_in || match;
   assign shift    = (seen_out || ctrl.full_miss) && ctrl.below_top;
   assign page_out = page_ff;

   // Select the new content of the slot.
   always_comb begin
      if (ctrl.write_here) begin
         page_in = req_page;
      end else if (shift) begin
         page_in = upper_page;
      end else begin
         page_in = page_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         page_ff <= page_in;
      end
   end

endmodule

// ===== rtl/core/lru_page_replacement.sv =====
// Channel | Direction | Handshake     | Payload
// req_bus | in        | valid / ready | page_number, last_ref
// rsp_bus | out       | valid / ready | hit, evicted_valid, evicted_page, fault_total,
//         |           |               | hit_total, is_last
// csr_bus | in        | valid / ready | cache_size
//
// One transaction a cycle while the output register can take it: every cell
// compares its page with the reference in parallel, and the chain shifts at the
// same clock edge that loads the result into the output register.
// The output register accepts a new reference whenever it is empty or being taken.
// Synchronous reset empties the stack, clears both totals and sets cache_size to 4;
// no transaction and no register write is taken while reset is high.
module lru_page_replacement (
   input  logic        clock,
   input  logic        reset,
   lrupr_req_if.sink   req_bus,
   lrupr_rsp_if.source rsp_bus,
   lrupr_csr_if.sink   csr_bus
);

   localparam int N = lrupr_pkg::MAX_SLOTS;

   logic [lrupr_pkg::CAP_W-1:0]   cap_ff;
   logic [lrupr_pkg::OCC_W-1:0]   occ_ff;
   logic [lrupr_pkg::OCC_W-1:0]   occ_in;
   logic [lrupr_pkg::OCC_W-1:0]   wr_pos;
   logic [lrupr_pkg::CMP_W-1:0]   eff_cap;
   logic [lrupr_pkg::COUNT_W-1:0] fault_ff;
   logic [lrupr_pkg::COUNT_W-1:0] fault_in;
   logic [lrupr_pkg::COUNT_W-1:0] hits_ff;
   logic [lrupr_pkg::COUNT_W-1:0] hits_in;

   logic                          rsp_valid_ff;
   logic                          rsp_hit_ff;
   logic                          rsp_ev_valid_ff;
   logic [lrupr_pkg::PAGE_W-1:0]  rsp_ev_page_ff;
   logic                          rsp_last_ff;

   logic                          accept;
   logic                          hit_any;
   logic                          full;
   logic                          full_miss;
   logic [N:0]                    seen;
   logic [lrupr_pkg::PAGE_W-1:0]  page_vec [N];
   lrupr_pkg::lrupr_ctrl_type     ctrl_vec [N];

   // Handshakes: the output register parts the two sides.
   assign req_bus.ready = !reset && (!rsp_valid_ff || rsp_bus.ready);
   assign csr_bus.ready = !reset;
   assign accept        = req_bus.valid && req_bus.ready;

   // Effective capacity: zero acts as one, anything above the built size as the size.
   always_comb begin
      if (cap_ff == '0) begin
         eff_cap = lrupr_pkg::CMP_W'(1);
      end else if (lrupr_pkg::CMP_W'(cap_ff) > lrupr_pkg::CMP_W'(N)) begin
         eff_cap = lrupr_pkg::CMP_W'(N);
      end else begin
         eff_cap = lrupr_pkg::CMP_W'(cap_ff);
      end
   end

   // Hit, fill state and the slot that receives the referenced page.
   assign hit_any   = seen[N];
   assign full      = lrupr_pkg::CMP_W'(occ_ff) >= eff_cap;
   assign full_miss = full && !hit_any;
   assign wr_pos    = (hit_any || full) ? occ_ff - lrupr_pkg::OCC_W'(1) : occ_ff;
   assign occ_in    = (hit_any || full) ? occ_ff : occ_ff + lrupr_pkg::OCC_W'(1);
   assign seen[0]   = 1'b0;

   // Saturating totals including this reference.
   assign fault_in = (!hit_any && (fault_ff != '1)) ? fault_ff + lrupr_pkg::COUNT_W'(1)
                                                     : fault_ff;
   assign hits_in  = (hit_any && (hits_ff != '1)) ? hits_ff + lrupr_pkg::COUNT_W'(1)
                                                   : hits_ff;

   // The chain of cells, least recent at index zero.
   for (genvar i = 0; i < N; i++) begin : g_cell
      logic [lrupr_pkg::PAGE_W-1:0] upper;

      if (i == N - 1) begin : g_top
         assign upper = '0;
      end else begin : g_mid
         assign upper = page_vec[i+1];
      end

      assign ctrl_vec[i].load       = accept;
      assign ctrl_vec[i].valid      = lrupr_pkg::OCC_W'(i) < occ_ff;
      assign ctrl_vec[i].below_top  = (lrupr_pkg::OCC_W'(i) + lrupr_pkg::OCC_W'(1)) < occ_ff;
      assign ctrl_vec[i].write_here = lrupr_pkg::OCC_W'(i) == wr_pos;
      assign ctrl_vec[i].full_miss  = full_miss;

      lrupr_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl_vec[i]),
         .req_page   (req_bus.page_number),
         .upper_page (upper),
         .seen_in    (seen[i]),
         .seen_out   (seen[i+1]),
         .page_out   (page_vec[i])
      );
   end

   // Control state, configuration and totals.
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= lrupr_pkg::CAP_RESET;
         occ_ff       <= '0;
         fault_ff     <= '0;
         hits_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_bus.valid && csr_bus.ready) begin
            cap_ff <= csr_bus.cache_size;
         end
         if (accept) begin
            occ_ff       <= occ_in;
            fault_ff     <= fault_in;
            hits_ff      <= hits_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Result payload register.
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_hit_ff      <= hit_any;
         rsp_ev_valid_ff <= full_miss;
         rsp_ev_page_ff  <= full_miss ? page_vec[0] : '0;
         rsp_last_ff     <= req_bus.last_ref;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.hit           = rsp_hit_ff;
   assign rsp_bus.evicted_valid = rsp_ev_valid_ff;
   assign rsp_bus.evicted_page  = rsp_ev_page_ff;
   assign rsp_bus.fault_total   = fault_ff;
   assign rsp_bus.hit_total     = hits_ff;
   assign rsp_bus.is_last       = rsp_last_ff;

endmodule

// ===== rtl/core/lrupr_checker.sv =====
`include "lru_page_replacement_assert.svh"

// Port-level checks of the page replacement block.
module lrupr_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          rsp_hit,
   input logic                          rsp_evicted_valid,
   input logic [lrupr_pkg::PAGE_W-1:0]  rsp_evicted_page
);

   // Reset leaves no result pending.
   `LRUPR_ASSERT_NEXT_ALWAYS(a_reset_empty, reset, !rsp_valid)

   // An eviction only happens on a page fault.
   `LRUPR_ASSERT_NOW(a_evict_on_miss, rsp_valid && rsp_evicted_valid, !rsp_hit)

   // Without an eviction the evicted page reads zero.
   `LRUPR_ASSERT_NOW(a_evict_page_zero, rsp_valid && !rsp_evicted_valid,
                     rsp_evicted_page == '0)

   // Every accepted transaction shows its result in the next cycle.
   `LRUPR_ASSERT_NEXT(a_one_cycle, req_valid && req_ready, rsp_valid)

   // A result that is held back stays on offer until it is taken.
   `LRUPR_ASSERT_NEXT(a_hold_valid, rsp_valid && !rsp_ready, rsp_valid)

endmodule

bind lru_page_replacement lrupr_checker u_lrupr_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_bus.valid),
   .req_ready         (req_bus.ready),
   .rsp_valid         (rsp_bus.valid),
   .rsp_ready         (rsp_bus.ready),
   .rsp_hit           (rsp_bus.hit),
   .rsp_evicted_valid (rsp_bus.evicted_valid),
   .rsp_evicted_page  (rsp_bus.evicted_page)
);
